[hdl/lscr_pkg.sv]
// lscr_pkg: shared constants and types for the line-scan camera readout
// used by the channel interfaces, the sequencer and the top level
`timescale 1ns / 1ps

package lscr_pkg;

  localparam int PIXELS   = 128;
  localparam int LAST     = 2 * PIXELS;
  localparam int CNT_W    = $clog2(LAST + 1) + 1;
  localparam int IDX_W    = 7;
  localparam int SAMPLE_W = 16;

  typedef logic signed [CNT_W-1:0] cnt_t;

  localparam cnt_t CNT_START = cnt_t'(-2);
  localparam cnt_t CNT_SI_ON = cnt_t'(-1);
  localparam cnt_t CNT_SI_OFF = cnt_t'(1);
  localparam cnt_t CNT_STREAM = cnt_t'(2);
  localparam cnt_t CNT_LAST   = cnt_t'(LAST);

  typedef enum logic {
    FUNC_ARM  = 1'b0,
    FUNC_TICK = 1'b1
  } func_t;

  typedef struct packed {
    logic                cam_clk;
    logic                cam_si;
    logic                pixel_valid;
    logic [IDX_W-1:0]    pixel_index;
    logic [SAMPLE_W-1:0] pixel_value;
    logic                line_done;
  } result_t;

endpackage

[hdl/lscr_if.sv]
// lscr_in_if / lscr_out_if: valid-ready channels for items and results
// depends on lscr_pkg
`timescale 1ns / 1ps

interface lscr_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [lscr_pkg::SAMPLE_W-1:0] adc_sample;

  modport source (output valid, output func, output adc_sample, input ready);
  modport sink   (input valid, input func, input adc_sample, output ready);
endinterface

interface lscr_out_if;
  logic                          valid;
  logic                          ready;
  logic                          cam_clk;
  logic                          cam_si;
  logic                          pixel_valid;
  logic [lscr_pkg::IDX_W-1:0]    pixel_index;
  logic [lscr_pkg::SAMPLE_W-1:0] pixel_value;
  logic                          line_done;

  modport source (output valid, output cam_clk, output cam_si, output pixel_valid,
                  output pixel_index, output pixel_value, output line_done,
                  input ready);
  modport sink   (input valid, input cam_clk, input cam_si, input pixel_valid,
                  input pixel_index, input pixel_value, input line_done,
                  output ready);
endinterface

[hdl/lscr_seq.sv]
// lscr_seq: readout sequencer state (phase counter, pin levels, armed flag)
// and the per-item result logic; depends on lscr_pkg
`timescale 1ns / 1ps

module lscr_seq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  logic                          func,
  input  logic [lscr_pkg::SAMPLE_W-1:0] adc_sample,
  output lscr_pkg::result_t             res
);

  lscr_pkg::cnt_t cnt_r, cnt_nxt;
  logic           clk_lvl_r, clk_lvl_nxt;
  logic           si_r, si_nxt;
  logic           armed_r, armed_nxt;
  logic           tog;

  always_comb begin
    cnt_nxt     = cnt_r;
    clk_lvl_nxt = clk_lvl_r;
    si_nxt      = si_r;
    armed_nxt   = armed_r;
    tog         = ~clk_lvl_r;
    res         = '0;
    if (lscr_pkg::func_t'(func) == lscr_pkg::FUNC_ARM) begin
      armed_nxt = 1'b1;
    end else if (armed_r) begin
      clk_lvl_nxt = tog;
      if (cnt_r >= lscr_pkg::CNT_STREAM && cnt_r < lscr_pkg::CNT_LAST) begin
        if (!tog) begin
          res.pixel_valid = 1'b1;
          res.pixel_index = cnt_r[lscr_pkg::IDX_W:1];
          res.pixel_value = adc_sample;
        end
        cnt_nxt = cnt_r + lscr_pkg::cnt_t'(1);
      end else if (cnt_r < lscr_pkg::CNT_STREAM) begin
        if (cnt_r == lscr_pkg::CNT_SI_ON) begin
          si_nxt = 1'b1;
        end else if (cnt_r == lscr_pkg::CNT_SI_OFF) begin
          si_nxt          = 1'b0;
          res.pixel_valid = 1'b1;
          res.pixel_value = adc_sample;
        end
        cnt_nxt = cnt_r + lscr_pkg::cnt_t'(1);
      end else begin
        clk_lvl_nxt   = 1'b0;
        cnt_nxt       = lscr_pkg::CNT_START;
        res.line_done = 1'b1;
        armed_nxt     = 1'b0;
      end
    end
    res.cam_clk = clk_lvl_nxt;
    res.cam_si  = si_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= lscr_pkg::CNT_START;
      clk_lvl_r <= 1'b0;
      si_r      <= 1'b0;
      armed_r   <= 1'b0;
    end else if (step_en) begin
      cnt_r     <= cnt_nxt;
      clk_lvl_r <= clk_lvl_nxt;
      si_r      <= si_nxt;
      armed_r   <= armed_nxt;
    end
  end

`ifndef ASSERT_OFF
  // disarm only through a finished line
  a_disarm_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(armed_r) |-> $past(step_en && res.line_done))
    else $error("sequencer disarmed without line done");

  // counter stays at start while idle
  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    !armed_r |-> cnt_r == lscr_pkg::CNT_START)
    else $error("phase counter moved while idle");

  // si is high only between its raise and drop counts
  a_si_window: assert property (@(posedge clk) disable iff (!rst_n)
    si_r |-> armed_r && (cnt_r == lscr_pkg::CNT_SI_ON + lscr_pkg::cnt_t'(1)
                      || cnt_r == lscr_pkg::CNT_SI_OFF))
    else $error("si high outside its window");
`endif

endmodule

[hdl/line_scan_camera_readout.sv]
// Line-scan camera readout: takes one item (arm or pixel-clock tick) per cycle and
// returns one result with the camera clock and SI levels, any captured pixel and
// line done. Each item passes through the combinational sequencer into the result
// register, so with out_ready held high a new item is accepted every cycle.
// Depends on lscr_pkg, lscr_in_if / lscr_out_if and lscr_seq.
`timescale 1ns / 1ps

module line_scan_camera_readout (
  input  logic              clk,
  input  logic              rst_n,
  lscr_in_if.sink           in_chan,
  lscr_out_if.source        out_chan
);

  lscr_pkg::result_t res;
  lscr_pkg::result_t res_r;
  logic              out_valid_r, out_valid_nxt;
  logic              step_en;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign step_en       = in_chan.valid && in_chan.ready;

  lscr_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .func       (in_chan.func),
    .adc_sample (in_chan.adc_sample),
    .res        (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.cam_clk     = res_r.cam_clk;
  assign out_chan.cam_si      = res_r.cam_si;
  assign out_chan.pixel_valid = res_r.pixel_valid;
  assign out_chan.pixel_index = res_r.pixel_index;
  assign out_chan.pixel_value = res_r.pixel_value;
  assign out_chan.line_done   = res_r.line_done;

`ifndef ASSERT_OFF
  // line done leaves the clock low and carries no pixel
  a_done_clk_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.line_done |-> !res_r.cam_clk && !res_r.pixel_valid)
    else $error("line done with clock high or pixel");

  // empty results carry zero pixel fields
  a_no_pixel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.pixel_valid |-> res_r.pixel_index == '0
                                       && res_r.pixel_value == '0)
    else $error("pixel fields nonzero without a pixel");

  // a waiting result is not overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |-> !step_en)
    else $error("item accepted over a waiting result");
`endif

endmodule

[tb/tb.sv]
// tb: self-checking testbench for line_scan_camera_readout, arm and tick items in,
// pin levels and pixels out, checked against an in-bench sequencer predictor
// depends on lscr_pkg, lscr_in_if / lscr_out_if and the line_scan_camera_readout rtl
`timescale 1ns / 1ps

module tb;

  localparam int RESET_CYCLES = 7;
  localparam int DRAIN_CYCLES = 10;
  localparam int STALL_LIMIT  = 4000;
  localparam int MAX_REPORTS  = 10;

  logic clk = 1'b0;
  logic rst_n;

  lscr_in_if  in_chan ();
  lscr_out_if out_chan ();

  line_scan_camera_readout DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #2 clk = ~clk;

  // predictor state
  lscr_pkg::cnt_t phase_r;
  logic           clk_r;
  logic           si_r;
  logic           armed_r;

  lscr_pkg::result_t expected_q[$];
  int                errors = 0;
  int                tx_gap_pct = 0;
  int                rx_stall_pct = 0;
  int                hold_left = 0;

  function automatic lscr_pkg::result_t predict_readout(
    lscr_pkg::func_t f, logic [lscr_pkg::SAMPLE_W-1:0] s);
    lscr_pkg::result_t r;
    r = '0;
    if (f == lscr_pkg::FUNC_ARM) begin
      armed_r = 1'b1;
    end else if (armed_r) begin
      clk_r = ~clk_r;
      if (phase_r >= lscr_pkg::CNT_STREAM && phase_r < lscr_pkg::CNT_LAST) begin
        // pixels 1..127 on falling clock edges
        if (!clk_r) begin
          r.pixel_valid = 1'b1;
          r.pixel_index = lscr_pkg::IDX_W'(phase_r >>> 1);
          r.pixel_value = s;
        end
        phase_r = phase_r + lscr_pkg::cnt_t'(1);
      end else if (phase_r < lscr_pkg::CNT_STREAM) begin
        if (phase_r == lscr_pkg::CNT_SI_ON) begin
          si_r = 1'b1;
        end else if (phase_r == lscr_pkg::CNT_SI_OFF) begin
          si_r          = 1'b0;
          r.pixel_valid = 1'b1;
          r.pixel_index = '0;
          r.pixel_value = s;
        end
        phase_r = phase_r + lscr_pkg::cnt_t'(1);
      end else begin
        // end of line
        clk_r       = 1'b0;
        phase_r     = lscr_pkg::CNT_START;
        r.line_done = 1'b1;
        armed_r     = 1'b0;
      end
    end
    r.cam_clk = clk_r;
    r.cam_si  = si_r;
    return r;
  endfunction

  function automatic logic [lscr_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return lscr_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_item(lscr_pkg::func_t f, logic [lscr_pkg::SAMPLE_W-1:0] s);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.func       <= f;
    in_chan.adc_sample <= s;
    do @(posedge clk); while (!in_chan.ready);
    expected_q.push_back(predict_readout(f, s));
  endtask

  task automatic apply_reset();
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.func       <= lscr_pkg::FUNC_ARM;
    in_chan.adc_sample <= '0;
    phase_r = lscr_pkg::CNT_START;
    clk_r   = 1'b0;
    si_r    = 1'b0;
    armed_r = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  task automatic test_idle_ticks();
    send_item(lscr_pkg::FUNC_TICK, '0);
    send_item(lscr_pkg::FUNC_TICK, '1);
  endtask

  task automatic test_arm_twice();
    send_item(lscr_pkg::FUNC_ARM, 16'h5555);
    send_item(lscr_pkg::FUNC_ARM, 16'hAAAA);
  endtask

  task automatic test_si_pulse();
    // walk through si high, si low with pixel 0, first streamed pixels
    send_item(lscr_pkg::FUNC_TICK, 16'hFFFF);
    send_item(lscr_pkg::FUNC_TICK, 16'h0000);
    send_item(lscr_pkg::FUNC_TICK, 16'hAAAA);
    send_item(lscr_pkg::FUNC_ARM,  16'h1234);
    send_item(lscr_pkg::FUNC_TICK, 16'h5555);
    send_item(lscr_pkg::FUNC_TICK, 16'hFFFF);
    send_item(lscr_pkg::FUNC_TICK, 16'h0000);
    send_item(lscr_pkg::FUNC_TICK, 16'h8001);
    send_item(lscr_pkg::FUNC_TICK, 16'h7FFE);
  endtask

  task automatic run_random_lines(int n_items);
    int              sent;
    lscr_pkg::func_t f;
    sent = 0;
    while (sent < n_items) begin
      if (!armed_r)
        f = ($urandom_range(99) < 85) ? lscr_pkg::FUNC_ARM : lscr_pkg::FUNC_TICK;
      else
        f = ($urandom_range(99) < 3)  ? lscr_pkg::FUNC_ARM : lscr_pkg::FUNC_TICK;
      if (armed_r || f == lscr_pkg::FUNC_ARM) sent++;
      send_item(f, pick_sample());
    end
  endtask

  task automatic test_random_phase(int gap_pct, int stall_pct, int n_items);
    tx_gap_pct   = gap_pct;
    rx_stall_pct = stall_pct;
    run_random_lines(n_items);
  endtask

  task automatic test_backpressure();
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    hold_left    = 150;
    run_random_lines(200);
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result checker, also owns out ready
  initial begin : result_sink
    lscr_pkg::result_t got;
    lscr_pkg::result_t want;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        got = {out_chan.cam_clk, out_chan.cam_si, out_chan.pixel_valid,
               out_chan.pixel_index, out_chan.pixel_value, out_chan.line_done};
        if (expected_q.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("unexpected result: clk=%0b si=%0b pv=%0b idx=%0d val=%h done=%0b",
                     got.cam_clk, got.cam_si, got.pixel_valid, got.pixel_index,
                     got.pixel_value, got.line_done);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (errors < MAX_REPORTS)
              $display("mismatch: exp clk=%0b si=%0b pv=%0b idx=%0d val=%h done=%0b",
                       want.cam_clk, want.cam_si, want.pixel_valid, want.pixel_index,
                       want.pixel_value, want.line_done,
                       " | got clk=%0b si=%0b pv=%0b idx=%0d val=%h done=%0b",
                       got.cam_clk, got.cam_si, got.pixel_valid, got.pixel_index,
                       got.pixel_value, got.line_done);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[line_scan_camera_readout] ERROR");
    $finish;
  end

  initial begin
    apply_reset();
    test_idle_ticks();
    test_arm_twice();
    test_si_pulse();
    test_random_phase(0, 0, 350);
    test_random_phase(60, 0, 350);
    test_random_phase(0, 60, 350);
    test_random_phase(14, 14, 350);
    test_backpressure();
    drain_results();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("[line_scan_camera_readout] OK");
    end else begin
      $display("[line_scan_camera_readout] ERROR");
    end
    $finish;
  end

endmodule
